// ===== sv/mvna_pkg.sv =====
// ---------------------------------------------------------------------------
// Vertex normal accumulator package
// Shared types and constants for the vertex normal accumulator.
// ---------------------------------------------------------------------------
package mvna_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_TRI  = 2'd1,
    ACT_READ = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRI_A,
    ST_TRI_B,
    ST_TRI_C,
    ST_TRI_MUL,
    ST_TRI_CROSS,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_RD_ABS,
    ST_RD_NORM,
    ST_RD_SQ,
    ST_RD_SUM,
    ST_RD_ROOT,
    ST_RD_PREP,
    ST_RD_DIV,
    ST_RD_OUT
  } state_t;

  localparam int IDX_W   = 10;
  localparam int POS_W   = 16;
  localparam int ACC_W   = 48;
  localparam int CROSS_W = 35;
  localparam int NRM_W   = 16;

endpackage

// ===== sv/mvna_if.sv =====
// ---------------------------------------------------------------------------
// Vertex normal accumulator channels
// Request, result and configuration channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
interface mvna_item_if import mvna_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [IDX_W-1:0]        vertex_index;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [IDX_W-1:0]        corner_a;
  logic [IDX_W-1:0]        corner_b;
  logic [IDX_W-1:0]        corner_c;

  modport source (output valid, action, vertex_index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink (input valid, action, vertex_index, pos_x, pos_y, pos_z,
                corner_a, corner_b, corner_c, output ready);
endinterface

interface mvna_result_if import mvna_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;
  logic                    zero_length;

  modport source (output valid, normal_x, normal_y, normal_z, zero_length,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, zero_length,
                output ready);
endinterface

interface mvna_cfg_if ();
  logic valid;
  logic ready;
  logic flat_shading;

  modport source (output valid, flat_shading, input ready);
  modport sink (input valid, flat_shading, output ready);
endinterface

// ===== sv/mesh_vertex_normal_accumulator_unit.sv =====
// ---------------------------------------------------------------------------
// Mesh vertex normal accumulator
// Position and normal-sum memories with triangle accumulation and readout.
// ---------------------------------------------------------------------------
// A triangle request makes three position reads and one read-modify-write of
// the accumulator memory per corner, through single-port memories; with flat
// shading only the first corner is accumulated. A read request runs the
// normalizing shifter, the 32-step square root and the 16-step divider; a
// read of a zero sum skips them, as does a read of a vertex out of range. A
// read also waits while an earlier result is still held. Requests are taken
// one at a time; a finished result waits in the output register while the
// next request runs.
module mesh_vertex_normal_accumulator_unit
  import mvna_pkg::*;
#(
  parameter int MAX_VERTICES = 1024
) (
  input  logic         clk,
  input  logic         rst,
  mvna_item_if.sink    item,
  mvna_result_if.source result,
  mvna_cfg_if.sink     cfg
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  state_t state, state_next;
  logic flat_shading;

  logic [3*POS_W-1:0] pos_mem [MAX_VERTICES];
  logic [3*ACC_W-1:0] acc_mem [MAX_VERTICES];
  logic [3*POS_W-1:0] pos_rdata, pos_wdata;
  logic [3*ACC_W-1:0] acc_rdata, acc_wdata;
  logic [AW-1:0]      pos_addr, acc_addr;
  logic               pos_we, acc_we;

  logic [AW-1:0] ca, cb, cc;
  logic [1:0]    corner;
  logic signed [POS_W:0]     ux, uy, uz, wx, wy, wz;
  logic signed [2*POS_W+1:0] p0, p1, p2, p3, p4, p5;
  logic signed [CROSS_W-1:0] crx, cry, crz;
  logic [ACC_W-1:0] m0, m1, m2;
  logic             s0, s1, s2, zflag;
  logic [59:0]      q0, q1, q2;
  logic [63:0]      rv, rres, rbit;
  logic [31:0]      len;
  logic [44:0]      r0, r1, r2;
  logic [46:0]      dsh;
  logic [NRM_W-1:0] d0, d1, d2;
  logic [3:0]       dcnt;
  logic             res_valid;

  logic accept, idx_ok, tri_ok, last_corner, out_free;
  logic [ACC_W-1:0] morv;
  logic [63:0] rtry;
  logic [AW-1:0] cur_corner;
  logic [ACC_W-1:0] acc_new_x, acc_new_y, acc_new_z;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                               input logic signed [CROSS_W-1:0] d);
    logic signed [ACC_W:0] s;
    s = $signed({acc[ACC_W-1], acc}) + (ACC_W+1)'(d);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic logic [ACC_W-1:0] mag(input logic [ACC_W-1:0] v);
    return v[ACC_W-1] ? (~v + 1'b1) : v;
  endfunction

  assign accept   = item.valid && item.ready;
  assign idx_ok   = 32'(item.vertex_index) < MAX_VERTICES;
  assign tri_ok   = (32'(item.corner_a) < MAX_VERTICES) &&
                    (32'(item.corner_b) < MAX_VERTICES) &&
                    (32'(item.corner_c) < MAX_VERTICES);
  assign out_free = !res_valid || result.ready;
  assign last_corner = (corner == 2'd2) || (flat_shading && corner == 2'd0);
  assign cur_corner  = (corner == 2'd0) ? ca : ((corner == 2'd1) ? cb : cc);
  assign morv = m0 | m1 | m2;
  assign rtry = rres + rbit;

  assign acc_new_z = sat_add(acc_rdata[ACC_W-1:0], crz);
  assign acc_new_y = sat_add(acc_rdata[2*ACC_W-1:ACC_W], cry);
  assign acc_new_x = sat_add(acc_rdata[3*ACC_W-1:2*ACC_W], crx);

  assign item.ready = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_addr] <= pos_wdata;
    end
    pos_rdata <= pos_mem[pos_addr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_addr] <= acc_wdata;
    end
    acc_rdata <= acc_mem[acc_addr];
  end

  always_comb begin
    state_next = state;
    pos_addr   = AW'(item.corner_a);
    pos_we     = 1'b0;
    pos_wdata  = {item.pos_x, item.pos_y, item.pos_z};
    acc_addr   = cur_corner;
    acc_we     = 1'b0;
    acc_wdata  = {acc_new_x, acc_new_y, acc_new_z};
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (item.action)
            ACT_LOAD: begin
              pos_addr  = AW'(item.vertex_index);
              acc_addr  = AW'(item.vertex_index);
              pos_we    = idx_ok;
              acc_we    = idx_ok;
              acc_wdata = '0;
            end
            ACT_TRI: begin
              if (tri_ok) begin
                state_next = ST_TRI_A;
              end
            end
            ACT_READ: begin
              acc_addr   = AW'(item.vertex_index);
              state_next = idx_ok ? ST_RD_ABS : ST_RD_OUT;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_TRI_A: begin
        pos_addr   = cb;
        state_next = ST_TRI_B;
      end
      ST_TRI_B: begin
        pos_addr   = cc;
        state_next = ST_TRI_C;
      end
      ST_TRI_C:     state_next = ST_TRI_MUL;
      ST_TRI_MUL:   state_next = ST_TRI_CROSS;
      ST_TRI_CROSS: state_next = ST_ACC_RD;
      ST_ACC_RD:    state_next = ST_ACC_WR;
      ST_ACC_WR: begin
        acc_we     = 1'b1;
        state_next = last_corner ? ST_IDLE : ST_ACC_RD;
      end
      ST_RD_ABS: state_next = ((acc_rdata == '0) ? ST_RD_OUT : ST_RD_NORM);
      ST_RD_NORM: begin
        if (morv[ACC_W-1:30] == '0 && morv[29]) begin
          state_next = ST_RD_SQ;
        end
      end
      ST_RD_SQ:   state_next = ST_RD_SUM;
      ST_RD_SUM:  state_next = ST_RD_ROOT;
      ST_RD_ROOT: if (rbit[0]) state_next = ST_RD_PREP;
      ST_RD_PREP: state_next = ST_RD_DIV;
      ST_RD_DIV:  if (dcnt == 4'd0) state_next = ST_RD_OUT;
      ST_RD_OUT:  if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      flat_shading <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        flat_shading <= cfg.flat_shading;
      end
      if (state == ST_RD_OUT && out_free) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        ca     <= AW'(item.corner_a);
        cb     <= AW'(item.corner_b);
        cc     <= AW'(item.corner_c);
        corner <= 2'd0;
        zflag  <= 1'b1;
      end
      ST_TRI_A: begin
        ux <= (POS_W+1)'($signed(pos_rdata[3*POS_W-1:2*POS_W]));
        uy <= (POS_W+1)'($signed(pos_rdata[2*POS_W-1:POS_W]));
        uz <= (POS_W+1)'($signed(pos_rdata[POS_W-1:0]));
        wx <= (POS_W+1)'($signed(pos_rdata[3*POS_W-1:2*POS_W]));
        wy <= (POS_W+1)'($signed(pos_rdata[2*POS_W-1:POS_W]));
        wz <= (POS_W+1)'($signed(pos_rdata[POS_W-1:0]));
      end
      ST_TRI_B: begin
        ux <= (POS_W+1)'($signed(pos_rdata[3*POS_W-1:2*POS_W])) - ux;
        uy <= (POS_W+1)'($signed(pos_rdata[2*POS_W-1:POS_W])) - uy;
        uz <= (POS_W+1)'($signed(pos_rdata[POS_W-1:0])) - uz;
      end
      ST_TRI_C: begin
        wx <= (POS_W+1)'($signed(pos_rdata[3*POS_W-1:2*POS_W])) - wx;
        wy <= (POS_W+1)'($signed(pos_rdata[2*POS_W-1:POS_W])) - wy;
        wz <= (POS_W+1)'($signed(pos_rdata[POS_W-1:0])) - wz;
      end
      ST_TRI_MUL: begin
        p0 <= uy * wz;
        p1 <= uz * wy;
        p2 <= uz * wx;
        p3 <= ux * wz;
        p4 <= ux * wy;
        p5 <= uy * wx;
      end
      ST_TRI_CROSS: begin
        crx <= CROSS_W'(p0) - CROSS_W'(p1);
        cry <= CROSS_W'(p2) - CROSS_W'(p3);
        crz <= CROSS_W'(p4) - CROSS_W'(p5);
      end
      ST_ACC_WR: corner <= corner + 2'd1;
      ST_RD_ABS: begin
        s0 <= acc_rdata[3*ACC_W-1];
        s1 <= acc_rdata[2*ACC_W-1];
        s2 <= acc_rdata[ACC_W-1];
        m0 <= mag(acc_rdata[3*ACC_W-1:2*ACC_W]);
        m1 <= mag(acc_rdata[2*ACC_W-1:ACC_W]);
        m2 <= mag(acc_rdata[ACC_W-1:0]);
        zflag <= (acc_rdata == '0);
      end
      ST_RD_NORM: begin
        if (morv[ACC_W-1:37] != '0) begin
          m0 <= m0 >> 8;
          m1 <= m1 >> 8;
          m2 <= m2 >> 8;
        end else if (morv[36:30] != '0) begin
          m0 <= m0 >> 1;
          m1 <= m1 >> 1;
          m2 <= m2 >> 1;
        end else if (morv[29:21] == '0) begin
          m0 <= m0 << 8;
          m1 <= m1 << 8;
          m2 <= m2 << 8;
        end else if (!morv[29]) begin
          m0 <= m0 << 1;
          m1 <= m1 << 1;
          m2 <= m2 << 1;
        end
      end
      ST_RD_SQ: begin
        q0 <= m0[29:0] * m0[29:0];
        q1 <= m1[29:0] * m1[29:0];
        q2 <= m2[29:0] * m2[29:0];
      end
      ST_RD_SUM: begin
        rv   <= 64'(q0) + 64'(q1) + 64'(q2);
        rres <= '0;
        rbit <= {2'b01, 62'b0};
      end
      ST_RD_ROOT: begin
        if (rv >= rtry) begin
          rv   <= rv - rtry;
          rres <= (rres >> 1) + rbit;
          len  <= 32'((rres >> 1) + rbit);
        end else begin
          rres <= rres >> 1;
          len  <= 32'(rres >> 1);
        end
        rbit <= rbit >> 2;
      end
      ST_RD_PREP: begin
        r0   <= {1'b0, m0[29:0], 14'b0} + 45'(len >> 1);
        r1   <= {1'b0, m1[29:0], 14'b0} + 45'(len >> 1);
        r2   <= {1'b0, m2[29:0], 14'b0} + 45'(len >> 1);
        dsh  <= {len[31:0], 15'b0};
        d0   <= '0;
        d1   <= '0;
        d2   <= '0;
        dcnt <= 4'd15;
      end
      ST_RD_DIV: begin
        if (47'(r0) >= dsh) r0 <= 45'(47'(r0) - dsh);
        if (47'(r1) >= dsh) r1 <= 45'(47'(r1) - dsh);
        if (47'(r2) >= dsh) r2 <= 45'(47'(r2) - dsh);
        d0   <= {d0[NRM_W-2:0], 47'(r0) >= dsh};
        d1   <= {d1[NRM_W-2:0], 47'(r1) >= dsh};
        d2   <= {d2[NRM_W-2:0], 47'(r2) >= dsh};
        dsh  <= dsh >> 1;
        dcnt <= dcnt - 4'd1;
      end
      ST_RD_OUT: begin
        if (out_free) begin
          result.normal_x    <= zflag ? '0 : (s0 ? -$signed(d0) : $signed(d0));
          result.normal_y    <= zflag ? '0 : (s1 ? -$signed(d1) : $signed(d1));
          result.normal_z    <= zflag ? '0 : (s2 ? -$signed(d2) : $signed(d2));
          result.zero_length <= zflag;
        end
      end
      default: ;
    endcase
  end

  assign result.valid = res_valid;

endmodule
